/* rtl/tfr_pkg.sv */
`default_nettype none

package tfr_pkg;

  localparam int unsigned FmtW     = 6;
  localparam int unsigned DimW     = 11;
  localparam int unsigned CntW     = 20;
  localparam int unsigned PalAddrW = 8;
  localparam int unsigned PalDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [FmtW-1:0] FMT_DIRECT32 = 6'h00;
  localparam logic [FmtW-1:0] FMT_DIRECT24 = 6'h01;
  localparam logic [FmtW-1:0] FMT_DIRECT16 = 6'h02;
  localparam logic [FmtW-1:0] FMT_INDEX8   = 6'h13;
  localparam logic [FmtW-1:0] FMT_INDEX4   = 6'h14;

  localparam logic [CfgIdxW-1:0] CFG_PIXEL_FORMAT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TEXTURE_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TEXTURE_HEIGHT = 2'd2;

  localparam logic [DimW-1:0] DIM_MAX = 11'd1024;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  function automatic rgba_t expand16(input logic [PalDataW-1:0] e);
    rgba_t p;
    p.red   = {e[4:0], 3'b000};
    p.green = {e[9:5], 3'b000};
    p.blue  = {e[14:10], 3'b000};
    p.alpha = e[15] ? 8'hFF : 8'h00;
    return p;
  endfunction

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    r = d;
    if (d == '0) r = DimW'(1);
    else if (d > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/tfr_palette_ram.sv */
`default_nettype none

module tfr_palette_ram (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [tfr_pkg::PalAddrW-1:0]  waddr_i,
  input  wire logic [tfr_pkg::PalDataW-1:0]  wdata_i,
  input  wire logic                          re_i,
  input  wire logic [tfr_pkg::PalAddrW-1:0]  raddr_i,
  output logic      [tfr_pkg::PalDataW-1:0]  rdata_o
);

  localparam int unsigned Depth = 2 ** tfr_pkg::PalAddrW;

  logic [tfr_pkg::PalDataW-1:0] mem [Depth];
  logic [tfr_pkg::PalDataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/tfr_pixel_unit.sv */
`default_nettype none

module tfr_pixel_unit (
  input  wire logic [tfr_pkg::FmtW-1:0]      fmt_i,
  input  wire logic [31:0]                   word_i,
  input  wire logic [tfr_pkg::PalDataW-1:0]  pal_i,
  output tfr_pkg::rgba_t                     pix_o
);

  always_comb begin
    unique case (fmt_i)
      tfr_pkg::FMT_DIRECT32: begin
        pix_o = '{red: word_i[7:0], green: word_i[15:8],
                  blue: word_i[23:16], alpha: word_i[31:24]};
      end
      tfr_pkg::FMT_DIRECT24: begin
        pix_o = '{red: word_i[7:0], green: word_i[15:8],
                  blue: word_i[23:16], alpha: 8'hFF};
      end
      tfr_pkg::FMT_DIRECT16: pix_o = tfr_pkg::expand16(word_i[15:0]);
      tfr_pkg::FMT_INDEX8,
      tfr_pkg::FMT_INDEX4:   pix_o = tfr_pkg::expand16(pal_i);
      default:               pix_o = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'hFF};
    endcase
  end

endmodule

`default_nettype wire

/* rtl/texel_format_to_rgba.sv */
`default_nettype none

// Texel to RGBA8888 converter. Texel items enter a one-entry work stage; the
// palette read for indexed formats is issued at transfer, so the palette RAM
// (one write and one read port, registered read) delivers the entry as the item
// reaches the work stage. Direct, index8 and unknown formats give one pixel per
// item. An index4 item gives a low-nibble and then a high-nibble pixel, the
// second omitted when the first is the texture's last: the second palette read
// uses the same read port, so input stalls while it is issued. Palette writes
// give no pixel. Output valid rises when the work stage passes its pixel to the
// output register; the index4 high-nibble pixel follows. Write the configuration
// only while idle; the pixel counter is not cleared by writes.

module texel_format_to_rgba (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tfr_pkg::DimW-1:0]     cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         func_i,
  input  wire logic [31:0]                  texel_word_i,
  input  wire logic [7:0]                   palette_index_i,
  input  wire logic [15:0]                  palette_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [7:0]                   red_o,
  output logic      [7:0]                   green_o,
  output logic      [7:0]                   blue_o,
  output logic      [7:0]                   alpha_o,
  output logic                              run_last_o,
  output logic                              texture_last_o
);

  logic [tfr_pkg::FmtW-1:0] fmt_q;
  logic [tfr_pkg::DimW-1:0] width_q, height_q;
  logic [tfr_pkg::CntW-1:0] last_idx_q, cnt_q, cnt_d;

  logic        s1_valid_q, s1_valid_d;
  logic        s1_phase_q, s1_phase_d;
  logic [31:0] s1_word_q;

  logic        in_xfer, texel_xfer, out_ready, s1_fire, is_idx4;
  logic        pix_last, second_rd, s1_done;
  logic        ram_re;
  logic [tfr_pkg::PalAddrW-1:0] ram_raddr;
  logic [tfr_pkg::PalDataW-1:0] ram_rdata;
  logic [2*tfr_pkg::DimW-1:0]   total;
  tfr_pkg::rgba_t               pix;

  logic           out_valid_q;
  tfr_pkg::rgba_t out_pix_q;
  logic           out_run_last_q, out_tex_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= tfr_pkg::FMT_DIRECT32;
      width_q  <= tfr_pkg::DimW'(1);
      height_q <= tfr_pkg::DimW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tfr_pkg::CFG_PIXEL_FORMAT:   fmt_q    <= cfg_data_i[tfr_pkg::FmtW-1:0];
        tfr_pkg::CFG_TEXTURE_WIDTH:  width_q  <= cfg_data_i;
        tfr_pkg::CFG_TEXTURE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign total = tfr_pkg::clamp_dim(width_q) * tfr_pkg::clamp_dim(height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idx_q <= '0;
    end else begin
      last_idx_q <= tfr_pkg::CntW'(total - (2*tfr_pkg::DimW)'(1));
    end
  end

  assign is_idx4    = (fmt_q == tfr_pkg::FMT_INDEX4);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign texel_xfer = in_xfer && !func_i;
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_ready;
  assign pix_last   = (cnt_q >= last_idx_q);
  assign second_rd  = s1_fire && is_idx4 && !s1_phase_q && !pix_last;
  assign s1_done    = s1_fire && !second_rd;
  assign in_stall_o = s1_valid_q && !s1_done;

  always_comb begin
    ram_re    = texel_xfer || second_rd;
    ram_raddr = texel_word_i[7:0];
    if (second_rd) begin
      ram_raddr = {4'h0, s1_word_q[7:4]};
    end else if (is_idx4) begin
      ram_raddr = {4'h0, texel_word_i[3:0]};
    end
  end

  tfr_palette_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer && func_i),
    .waddr_i (palette_index_i),
    .wdata_i (palette_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tfr_pixel_unit u_pix (
    .fmt_i  (fmt_q),
    .word_i (s1_word_q),
    .pal_i  (ram_rdata),
    .pix_o  (pix)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_phase_d = s1_phase_q;
    if (texel_xfer) begin
      s1_valid_d = 1'b1;
      s1_phase_d = 1'b0;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end else if (second_rd) begin
      s1_phase_d = 1'b1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (s1_fire) begin
      cnt_d = pix_last ? '0 : cnt_q + tfr_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_phase_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_phase_q <= s1_phase_d;
      cnt_q      <= cnt_d;
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (texel_xfer) begin
      s1_word_q <= texel_word_i;
    end
    if (s1_fire) begin
      out_pix_q      <= pix;
      out_run_last_q <= !second_rd;
      out_tex_last_q <= pix_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_o          = out_pix_q.red;
  assign green_o        = out_pix_q.green;
  assign blue_o         = out_pix_q.blue;
  assign alpha_o        = out_pix_q.alpha;
  assign run_last_o     = out_run_last_q;
  assign texture_last_o = out_tex_last_q;

endmodule

`default_nettype wire
